// File: src/qap_pkg.sv
// Shared constants, codes and types of the quantized average pooling block.
package qap_pkg;

	// Fixed widths of the item and result fields
	localparam int ROW_W      = 6;
	localparam int COL_W      = 6;
	localparam int CH_W       = 6;
	localparam int SAMPLE_W   = 16;
	localparam int VALUE_W    = 16;

	// Register widths and configuration port
	localparam int DIM_W      = 7;
	localparam int POOL_W     = 4;
	localparam int SHIFT_W    = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_QUERY   = 1'b1;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// Clamp negative window sums to zero before the division
	localparam bit RELU_ENABLE = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_HEIGHT,
		REG_IN_WIDTH,
		REG_CHANNELS,
		REG_POOL_ROWS,
		REG_POOL_COLS,
		REG_STRIDE_ROWS,
		REG_STRIDE_COLS,
		REG_SCALE_SHIFT
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_MUL,
		ST_ADDR,
		ST_CHECK,
		ST_WALK,
		ST_DRAIN,
		ST_PREP,
		ST_DIV,
		ST_SHIFT,
		ST_SAT,
		ST_RESULT
	} state_t;

endpackage

// File: src/qap_if.sv
// Valid/ready channel interfaces for items and results.
interface qap_item_if;
	import qap_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [ROW_W-1:0]           row;
	logic [COL_W-1:0]           col;
	logic [CH_W-1:0]            channel;
	logic signed [SAMPLE_W-1:0] sample;

	modport source(output valid, mode, row, col, channel, sample, input ready);
	modport sink(input valid, mode, row, col, channel, sample, output ready);
endinterface

interface qap_result_if;
	import qap_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] pooled_value;
	logic                      status;

	modport source(output valid, pooled_value, status, input ready);
	modport sink(input valid, pooled_value, status, output ready);
endinterface

// File: src/qap_map_mem.sv
// Feature map storage: one write port, one registered read port.
module qap_map_mem #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/qap_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module qap_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// Bring down the next numerator bit and try a subtract
	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= numer;
			rem_q  <= '0;
			den_q  <= denom;
		end else if (run_q) begin
			quot_q <= {quot_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: src/quantized_average_pool_2d.sv
// Quantized 2-D average pooling over a feature map held in on-chip memory.
//
// Items arrive on the items channel and results leave on the results channel,
// both valid/ready; a transfer happens on a clock edge with valid and ready high.
// A load item (mode 0) writes one sample into the map if it lies in range and
// gives no result. A query item (mode 1) reads its window from the map one word
// per cycle, sums it, divides by the window area in a bit-serial divider and
// scales and saturates the quotient. The divider works through the SUM_W bits
// of the sum, where SUM_W is DATA_WIDTH + log2(MAX_POOL^2) (22 by default); the
// window walk and the divider set the time a query takes. A query outside the
// output map returns status 1 without reading the map. One item is worked on
// at a time; items.ready is high only while the block is idle.
// A finished result waits in an output register, so the next item can be taken
// while the receiver stalls; a second result waits until that register empties.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce it. Reset loads the register defaults;
// map contents are undefined until loaded.
module quantized_average_pool_2d #(
	parameter int MAP_WORDS  = 4096,
	parameter int DATA_WIDTH = 16,
	parameter int MAX_POOL   = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	qap_item_if.sink                       items,
	qap_result_if.source                   results,
	input  logic                           cfg_we,
	input  logic [qap_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qap_pkg::CFG_DATA_W-1:0] cfg_data
);

	import qap_pkg::*;

	localparam int AW       = $clog2(MAP_WORDS);
	localparam int CNT_W    = $clog2(MAX_POOL + 1);
	localparam int AREA_W   = $clog2(MAX_POOL * MAX_POOL + 1);
	localparam int SUM_W    = DATA_WIDTH + $clog2(MAX_POOL * MAX_POOL);
	localparam int SH_W     = SUM_W + 16;
	localparam int R0_W     = 11;
	localparam int RW_W     = 18;
	localparam int PITCH_W  = 2 * DIM_W;
	localparam int ADR_CW   = 27;
	localparam int OUT_BITS = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;

	localparam longint DHI_L = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam longint OHI_L = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
	localparam logic signed [32:0]     DHI = 33'(DHI_L);
	localparam logic signed [32:0]     DLO = 33'(-DHI_L - 64'sd1);
	localparam logic signed [SH_W-1:0] OHI = SH_W'(OHI_L);
	localparam logic signed [SH_W-1:0] OLO = SH_W'(-OHI_L - 64'sd1);

	// Configuration registers
	logic [DIM_W-1:0]          height_q;
	logic [DIM_W-1:0]          width_q;
	logic [DIM_W-1:0]          nch_q;
	logic [POOL_W-1:0]         pool_r_q;
	logic [POOL_W-1:0]         pool_c_q;
	logic [POOL_W-1:0]         stride_r_q;
	logic [POOL_W-1:0]         stride_c_q;
	logic signed [SHIFT_W-1:0] shift_q;

	// Latched item
	logic                      mode_q;
	logic [ROW_W-1:0]          row_q;
	logic [COL_W-1:0]          col_q;
	logic [CH_W-1:0]           ch_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	// Address calculation
	logic [R0_W-1:0]           r0_q;
	logic [R0_W-1:0]           c0_q;
	logic [CNT_W-1:0]          pr_q;
	logic [CNT_W-1:0]          pc_q;
	logic [R0_W-1:0]           rlim_q;
	logic [R0_W-1:0]           clim_q;
	logic [RW_W-1:0]           rw_q;
	logic [RW_W-1:0]           lr_q;
	logic [PITCH_W-1:0]        pitch_q;
	logic [AREA_W-1:0]         area_q;
	logic [ADR_CW-1:0]         base_q;
	logic [ADR_CW-1:0]         last_q;

	// Window walk and accumulation
	logic [AW-1:0]             addr_q;
	logic [AW-1:0]             rowaddr_q;
	logic [CNT_W-1:0]          x_q;
	logic [CNT_W-1:0]          y_q;
	logic                      rd_vld_s1;
	logic signed [SUM_W-1:0]   sum_q;
	logic                      neg_q;
	logic signed [SH_W-1:0]    shifted_q;

	// Result
	logic signed [VALUE_W-1:0] res_value_q;
	logic                      res_status_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_status_q;

	state_t state_q, state_d;

	logic [CNT_W-1:0]          pr_fix;
	logic [CNT_W-1:0]          pc_fix;
	logic [POOL_W-1:0]         sy_fix;
	logic [POOL_W-1:0]         sx_fix;
	logic                      load_ok;
	logic                      query_bad;
	logic                      x_last;
	logic                      y_last;
	logic [AW-1:0]             next_row;
	logic signed [SUM_W-1:0]   sum_rel;
	logic [SUM_W-1:0]          mag;
	logic signed [SUM_W-1:0]   avg;
	logic signed [SH_W-1:0]    avg_ext;
	logic [SHIFT_W-1:0]        lsh;
	logic signed [32:0]        sample_ext;
	logic signed [32:0]        sample_sat;
	logic [DATA_WIDTH-1:0]     rdata;
	logic [SUM_W-1:0]          quot;
	logic                      div_done;
	logic                      push;

	logic                      in_ready;
	logic                      mem_we;
	logic                      mem_re;
	logic                      div_start;

	//------------------------------------------------------------------
	// Configuration
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q   <= DIM_W'(1);
			width_q    <= DIM_W'(1);
			nch_q      <= DIM_W'(1);
			pool_r_q   <= POOL_W'(2);
			pool_c_q   <= POOL_W'(2);
			stride_r_q <= POOL_W'(2);
			stride_c_q <= POOL_W'(2);
			shift_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IN_HEIGHT:   height_q   <= cfg_data;
				REG_IN_WIDTH:    width_q    <= cfg_data;
				REG_CHANNELS:    nch_q      <= cfg_data;
				REG_POOL_ROWS:   pool_r_q   <= cfg_data[POOL_W-1:0];
				REG_POOL_COLS:   pool_c_q   <= cfg_data[POOL_W-1:0];
				REG_STRIDE_ROWS: stride_r_q <= cfg_data[POOL_W-1:0];
				REG_STRIDE_COLS: stride_c_q <= cfg_data[POOL_W-1:0];
				REG_SCALE_SHIFT: shift_q    <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero sizes act as one; pool sizes cap at MAX_POOL
	always_comb begin
		if (pool_r_q == '0) begin
			pr_fix = CNT_W'(1);
		end else if ({1'b0, pool_r_q} > 5'(MAX_POOL)) begin
			pr_fix = CNT_W'(MAX_POOL);
		end else begin
			pr_fix = CNT_W'(pool_r_q);
		end
		if (pool_c_q == '0) begin
			pc_fix = CNT_W'(1);
		end else if ({1'b0, pool_c_q} > 5'(MAX_POOL)) begin
			pc_fix = CNT_W'(MAX_POOL);
		end else begin
			pc_fix = CNT_W'(pool_c_q);
		end
		sy_fix = (stride_r_q == '0) ? POOL_W'(1) : stride_r_q;
		sx_fix = (stride_c_q == '0) ? POOL_W'(1) : stride_c_q;
	end

	//------------------------------------------------------------------
	// Sequencer
	//------------------------------------------------------------------
	assign load_ok = ({1'b0, row_q} < height_q) && ({1'b0, col_q} < width_q)
		&& ({1'b0, ch_q} < nch_q) && (base_q < ADR_CW'(MAP_WORDS));
	assign query_bad = ({1'b0, ch_q} >= nch_q) || (rlim_q > R0_W'(height_q))
		|| (clim_q > R0_W'(width_q)) || (last_q >= ADR_CW'(MAP_WORDS));
	assign x_last = (x_q == pc_q - 1'b1);
	assign y_last = (y_q == pr_q - 1'b1);
	assign push   = (state_q == ST_RESULT) && (!out_valid_q || results.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (items.valid) state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_MUL;
			ST_MUL:    state_d = ST_ADDR;
			ST_ADDR:   state_d = ST_CHECK;
			ST_CHECK: begin
				if (mode_q == MODE_LOAD) begin
					state_d = ST_IDLE;
				end else if (query_bad) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK:   if (x_last && y_last) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_PREP;
			ST_PREP:   state_d = ST_DIV;
			ST_DIV:    if (div_done) state_d = ST_SHIFT;
			ST_SHIFT:  state_d = ST_SAT;
			ST_SAT:    state_d = ST_RESULT;
			ST_RESULT: if (push) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready  = 1'b1;
			ST_CHECK: mem_we    = (mode_q == MODE_LOAD) && load_ok;
			ST_WALK:  mem_re    = 1'b1;
			ST_PREP:  div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re;
		end
	end

	//------------------------------------------------------------------
	// Datapath
	//------------------------------------------------------------------
	assign next_row = rowaddr_q + AW'(pitch_q);
	assign sum_rel  = (RELU_ENABLE && sum_q[SUM_W-1]) ? '0 : sum_q;
	assign mag      = sum_rel[SUM_W-1] ? SUM_W'(-sum_rel) : SUM_W'(sum_rel);
	assign avg      = neg_q ? -$signed(quot) : $signed(quot);
	assign avg_ext  = SH_W'(avg);
	assign lsh      = SHIFT_W'(~shift_q) + SHIFT_W'(1);

	// Saturate a sample to the stored word width
	always_comb begin
		sample_ext = 33'(sample_q);
		if (sample_ext > DHI) begin
			sample_sat = DHI;
		end else if (sample_ext < DLO) begin
			sample_sat = DLO;
		end else begin
			sample_sat = sample_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && items.valid) begin
			mode_q   <= items.mode;
			row_q    <= items.row;
			col_q    <= items.col;
			ch_q     <= items.channel;
			sample_q <= items.sample;
		end
		if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'($signed(rdata));
		end
		unique case (state_q)
			ST_SCALE: begin
				if (mode_q == MODE_QUERY) begin
					r0_q <= R0_W'(row_q) * R0_W'(sy_fix);
					c0_q <= R0_W'(col_q) * R0_W'(sx_fix);
				end else begin
					r0_q <= R0_W'(row_q);
					c0_q <= R0_W'(col_q);
				end
				pr_q <= pr_fix;
				pc_q <= pc_fix;
			end
			ST_MUL: begin
				rw_q    <= RW_W'(r0_q) * RW_W'(width_q);
				lr_q    <= RW_W'(r0_q + R0_W'(pr_q) - R0_W'(1)) * RW_W'(width_q);
				rlim_q  <= r0_q + R0_W'(pr_q);
				clim_q  <= c0_q + R0_W'(pc_q);
				pitch_q <= PITCH_W'(width_q) * PITCH_W'(nch_q);
				area_q  <= AREA_W'(pr_q) * AREA_W'(pc_q);
			end
			ST_ADDR: begin
				base_q <= (ADR_CW'(rw_q) + ADR_CW'(c0_q)) * ADR_CW'(nch_q) + ADR_CW'(ch_q);
				last_q <= (ADR_CW'(lr_q) + ADR_CW'(clim_q) - ADR_CW'(1)) * ADR_CW'(nch_q)
					+ ADR_CW'(ch_q);
			end
			ST_CHECK: begin
				addr_q       <= base_q[AW-1:0];
				rowaddr_q    <= base_q[AW-1:0];
				x_q          <= '0;
				y_q          <= '0;
				sum_q        <= '0;
				res_value_q  <= '0;
				res_status_q <= STATUS_RANGE;
			end
			ST_WALK: begin
				// Step along the row, then jump to the next window row
				if (x_last) begin
					x_q       <= '0;
					y_q       <= y_q + 1'b1;
					rowaddr_q <= next_row;
					addr_q    <= next_row;
				end else begin
					x_q    <= x_q + 1'b1;
					addr_q <= addr_q + AW'(nch_q);
				end
			end
			ST_PREP:  neg_q <= sum_rel[SUM_W-1];
			ST_SHIFT: begin
				if (shift_q[SHIFT_W-1]) begin
					shifted_q <= avg_ext <<< lsh;
				end else begin
					shifted_q <= avg_ext >>> shift_q[SHIFT_W-2:0];
				end
			end
			ST_SAT: begin
				if (shifted_q > OHI) begin
					res_value_q <= VALUE_W'(OHI);
				end else if (shifted_q < OLO) begin
					res_value_q <= VALUE_W'(OLO);
				end else begin
					res_value_q <= VALUE_W'(shifted_q);
				end
				res_status_q <= STATUS_OK;
			end
			default: ;
		endcase
	end

	//------------------------------------------------------------------
	// Output register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	assign items.ready          = in_ready;
	assign results.valid        = out_valid_q;
	assign results.pooled_value = out_value_q;
	assign results.status       = out_status_q;

	//------------------------------------------------------------------
	// Units
	//------------------------------------------------------------------
	qap_map_mem #(
		.DEPTH(MAP_WORDS),
		.WIDTH(DATA_WIDTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(base_q[AW-1:0]),
		.wdata(DATA_WIDTH'(sample_sat)),
		.re   (mem_re),
		.raddr(addr_q),
		.rdata(rdata)
	);

	qap_div #(
		.NUM_W(SUM_W),
		.DEN_W(AREA_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (mag),
		.denom (area_q),
		.done  (div_done),
		.quot  (quot)
	);

endmodule
